### src/bfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Banked file register ALU package
// Shared widths, instruction codes, status bit positions and the ALU result
// type of the banked file register ALU.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int unsigned MemBytes = 4096;
  localparam int unsigned AddrW    = $clog2(MemBytes);
  localparam int unsigned DataW    = 8;
  localparam int unsigned FlagW    = 5;
  localparam int unsigned BankW    = AddrW - DataW;
  localparam int unsigned OpW      = 5;

  localparam int unsigned FlagC  = 0;
  localparam int unsigned FlagDc = 1;
  localparam int unsigned FlagZ  = 2;
  localparam int unsigned FlagOv = 3;
  localparam int unsigned FlagN  = 4;

  typedef enum logic [OpW-1:0] {
    OP_ADDWF  = 5'd0,
    OP_ADDWFC = 5'd1,
    OP_ANDWF  = 5'd2,
    OP_IORWF  = 5'd3,
    OP_XORWF  = 5'd4,
    OP_SUBWF  = 5'd5,
    OP_SUBWFB = 5'd6,
    OP_SUBFWB = 5'd7,
    OP_COMF   = 5'd8,
    OP_DECF   = 5'd9,
    OP_INCF   = 5'd10,
    OP_MOVF   = 5'd11,
    OP_CLRF   = 5'd12,
    OP_MOVWF  = 5'd13,
    OP_ADDLW  = 5'd14,
    OP_SUBLW  = 5'd15,
    OP_ANDLW  = 5'd16,
    OP_IORLW  = 5'd17,
    OP_XORLW  = 5'd18,
    OP_MOVLW  = 5'd19
  } op_e;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [FlagW-1:0] flags;
    logic             valid;
    logic             literal_op;
    logic             force_file;
  } alu_res_t;

endpackage
`default_nettype wire

### src/bfr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Banked file register ALU channels
// Valid/ready channels for instruction words, result words and bank writes.
// ----------------------------------------------------------------------------
interface bfr_in_if import bfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [DataW-1:0] file_address;
  logic             dest_to_file;
  logic             use_bank;
  logic [DataW-1:0] literal;

  modport source (output valid, op, file_address, dest_to_file, use_bank, literal,
                  input ready);
  modport sink (input valid, op, file_address, dest_to_file, use_bank, literal,
                output ready);
endinterface

interface bfr_out_if import bfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] result_value;
  logic [DataW-1:0] working_reg;
  logic [FlagW-1:0] status_flags;
  logic [AddrW-1:0] written_address;
  logic             file_written;

  modport source (output valid, result_value, working_reg, status_flags,
                  written_address, file_written, input ready);
  modport sink (input valid, result_value, working_reg, status_flags,
                written_address, file_written, output ready);
endinterface

interface bfr_cfg_if import bfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BankW-1:0] bank_select;

  modport source (output valid, bank_select, input ready);
  modport sink (input valid, bank_select, output ready);
endinterface
`default_nettype wire

### src/bfr_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Banked file register ALU execute unit
// Decodes one instruction and produces its result byte and new status from
// the file operand, the working register, the status and the literal.
// ----------------------------------------------------------------------------
module bfr_alu import bfr_pkg::*; (
  input  logic [OpW-1:0]   op_i,
  input  logic [DataW-1:0] file_val_i,
  input  logic [DataW-1:0] work_i,
  input  logic [FlagW-1:0] flags_i,
  input  logic [DataW-1:0] literal_i,
  output alu_res_t         res_o
);

  logic [DataW-1:0] add_a;
  logic [DataW-1:0] add_b;
  logic             add_cin;
  logic [DataW:0]   sum;
  logic [4:0]       nib;
  logic [FlagW-1:0] add_flags;
  logic [DataW-1:0] logic_r;
  logic [FlagW-1:0] zn_flags;

  always_comb begin
    add_a   = work_i;
    add_b   = file_val_i;
    add_cin = 1'b0;
    case (op_i)
      OP_ADDWF: begin
      end
      OP_ADDWFC: begin
        add_cin = flags_i[FlagC];
      end
      OP_SUBWF: begin
        add_a   = file_val_i;
        add_b   = ~work_i;
        add_cin = 1'b1;
      end
      OP_SUBWFB: begin
        add_a   = file_val_i;
        add_b   = ~work_i;
        add_cin = flags_i[FlagC];
      end
      OP_SUBFWB: begin
        add_b   = ~file_val_i;
        add_cin = flags_i[FlagC];
      end
      OP_DECF: begin
        add_a = file_val_i;
        add_b = '1;
      end
      OP_INCF: begin
        add_a   = file_val_i;
        add_b   = '0;
        add_cin = 1'b1;
      end
      OP_ADDLW: begin
        add_b = literal_i;
      end
      OP_SUBLW: begin
        add_a   = literal_i;
        add_b   = ~work_i;
        add_cin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sum = {1'b0, add_a} + {1'b0, add_b} + {{DataW{1'b0}}, add_cin};
  assign nib = {1'b0, add_a[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};

  always_comb begin
    add_flags         = '0;
    add_flags[FlagC]  = sum[DataW];
    add_flags[FlagDc] = nib[4];
    add_flags[FlagZ]  = (sum[DataW-1:0] == '0);
    add_flags[FlagOv] = ~(add_a[DataW-1] ^ add_b[DataW-1]) &
                        (add_a[DataW-1] ^ sum[DataW-1]);
    add_flags[FlagN]  = sum[DataW-1];
  end

  always_comb begin
    case (op_i)
      OP_ANDWF: logic_r = work_i & file_val_i;
      OP_IORWF: logic_r = work_i | file_val_i;
      OP_XORWF: logic_r = work_i ^ file_val_i;
      OP_COMF:  logic_r = ~file_val_i;
      OP_MOVF:  logic_r = file_val_i;
      OP_ANDLW: logic_r = work_i & literal_i;
      OP_IORLW: logic_r = work_i | literal_i;
      OP_XORLW: logic_r = work_i ^ literal_i;
      default:  logic_r = '0;
    endcase
    zn_flags        = flags_i;
    zn_flags[FlagZ] = (logic_r == '0);
    zn_flags[FlagN] = logic_r[DataW-1];
  end

  always_comb begin
    res_o.value      = '0;
    res_o.flags      = flags_i;
    res_o.valid      = 1'b1;
    res_o.literal_op = 1'b0;
    res_o.force_file = 1'b0;
    case (op_i)
      OP_ADDWF, OP_ADDWFC, OP_SUBWF, OP_SUBWFB, OP_SUBFWB, OP_DECF,
      OP_INCF: begin
        res_o.value = sum[DataW-1:0];
        res_o.flags = add_flags;
      end
      OP_ANDWF, OP_IORWF, OP_XORWF, OP_COMF, OP_MOVF: begin
        res_o.value = logic_r;
        res_o.flags = zn_flags;
      end
      OP_CLRF: begin
        res_o.flags[FlagZ] = 1'b1;
        res_o.force_file   = 1'b1;
      end
      OP_MOVWF: begin
        res_o.value      = work_i;
        res_o.force_file = 1'b1;
      end
      OP_ADDLW, OP_SUBLW: begin
        res_o.value      = sum[DataW-1:0];
        res_o.flags      = add_flags;
        res_o.literal_op = 1'b1;
      end
      OP_ANDLW, OP_IORLW, OP_XORLW: begin
        res_o.value      = logic_r;
        res_o.flags      = zn_flags;
        res_o.literal_op = 1'b1;
      end
      OP_MOVLW: begin
        res_o.value      = literal_i;
        res_o.literal_op = 1'b1;
      end
      default: begin
        res_o.valid = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/banked_file_register_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Banked file register ALU
// Accumulator ALU that executes one byte-oriented or literal instruction per
// word against a working register, a status register and a 4096-byte data
// memory addressed through a bank register or the access bank.
//
//   Channel  Dir  Word
//   in_i     in   op, file_address, dest_to_file, use_bank, literal
//   out_o    out  result_value, working_reg, status_flags, written_address,
//                 file_written
//   cfg_i    in   bank_select
//
// One instruction per cycle while the result channel does not stall; each
// goes from acceptance to its result word through the synchronous data memory
// read, then execute and write back. A one-entry bypass of the last memory write
// covers a read that overlaps the write of the previous instruction.
// After reset the data memory is cleared one byte a cycle, all 4096 bytes,
// while no instruction is accepted. Bank writes are always accepted.
// A stalled result holds the execute stage, which holds the input channel.
// ----------------------------------------------------------------------------
module banked_file_register_alu import bfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfr_in_if.sink      in_i,
  bfr_out_if.source   out_o,
  bfr_cfg_if.sink     cfg_i
);

  logic [DataW-1:0] mem [MemBytes];
  logic [DataW-1:0] mem_rdata_q;

  logic             clr_q, clr_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic [BankW-1:0] bank_q;

  logic             s1_valid_q;
  logic [OpW-1:0]   s1_op_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_to_file_q;
  logic [DataW-1:0] s1_lit_q;

  logic             lw_valid_q;
  logic [AddrW-1:0] lw_addr_q;
  logic [DataW-1:0] lw_data_q;

  logic [DataW-1:0] acc_q;
  logic [FlagW-1:0] flags_q;

  logic             out_valid_q;
  logic [DataW-1:0] out_result_q;
  logic [DataW-1:0] out_work_q;
  logic [FlagW-1:0] out_flags_q;
  logic [AddrW-1:0] out_addr_q;
  logic             out_written_q;

  logic             in_accept;
  logic [AddrW-1:0] in_addr;
  logic             s1_adv;
  logic             commit;
  logic [DataW-1:0] file_val;
  alu_res_t         alu_res;
  logic             file_wr;
  logic [DataW-1:0] next_acc;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;

  assign cfg_i.ready = 1'b1;

  assign s1_adv    = !out_valid_q || out_o.ready;
  assign commit    = s1_valid_q && s1_adv;
  assign in_i.ready = !clr_q && (!s1_valid_q || s1_adv);
  assign in_accept = in_i.valid && in_i.ready;

  always_comb begin
    if (in_i.use_bank) begin
      in_addr = {bank_q, in_i.file_address};
    end else if (in_i.file_address[DataW-1]) begin
      in_addr = {{BankW{1'b1}}, in_i.file_address};
    end else begin
      in_addr = {{BankW{1'b0}}, in_i.file_address};
    end
  end

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == AddrW'(MemBytes - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      bank_q    <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      if (cfg_i.valid && cfg_i.ready) begin
        bank_q <= cfg_i.bank_select;
      end
    end
  end

  // The byte written by the previous instruction is not yet visible in a read
  // issued at the same edge, so it is taken from the bypass register.
  assign file_val = (lw_valid_q && (lw_addr_q == s1_addr_q)) ? lw_data_q : mem_rdata_q;

  bfr_alu u_alu (
    .op_i       (s1_op_q),
    .file_val_i (file_val),
    .work_i     (acc_q),
    .flags_i    (flags_q),
    .literal_i  (s1_lit_q),
    .res_o      (alu_res)
  );

  assign file_wr  = alu_res.valid && !alu_res.literal_op &&
                    (alu_res.force_file || s1_to_file_q);
  assign next_acc = (alu_res.valid && !file_wr) ? alu_res.value : acc_q;

  assign mem_we    = clr_q || (commit && file_wr);
  assign mem_waddr = clr_q ? clr_cnt_q : s1_addr_q;
  assign mem_wdata = clr_q ? '0 : alu_res.value;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      mem_rdata_q <= mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      lw_valid_q  <= 1'b0;
      acc_q       <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (commit) begin
        s1_valid_q <= 1'b0;
      end
      if (commit) begin
        acc_q       <= next_acc;
        flags_q     <= alu_res.flags;
        out_valid_q <= 1'b1;
        if (file_wr) begin
          lw_valid_q <= 1'b1;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q      <= in_i.op;
      s1_addr_q    <= in_addr;
      s1_to_file_q <= in_i.dest_to_file;
      s1_lit_q     <= in_i.literal;
    end
    if (commit) begin
      out_result_q  <= alu_res.valid ? alu_res.value : '0;
      out_work_q    <= next_acc;
      out_flags_q   <= alu_res.flags;
      out_addr_q    <= file_wr ? s1_addr_q : '0;
      out_written_q <= file_wr;
      if (file_wr) begin
        lw_addr_q <= s1_addr_q;
        lw_data_q <= alu_res.value;
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.result_value    = out_result_q;
  assign out_o.working_reg     = out_work_q;
  assign out_o.status_flags    = out_flags_q;
  assign out_o.written_address = out_addr_q;
  assign out_o.file_written    = out_written_q;

  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_q |-> !in_i.ready
  ) else $error("instruction accepted during memory clear");

  a_addr_zero_without_write : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_written_q) |-> (out_addr_q == '0)
  ) else $error("written address set without a memory write");

  a_stalled_stage_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_addr_q) && $stable(s1_op_q))
  ) else $error("execute stage lost a stalled instruction");

  a_accept_needs_room : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!s1_valid_q || commit)
  ) else $error("instruction accepted over a held one");

endmodule
`default_nettype wire
